[rtl/bfa_pkg.sv]
package bfa_pkg;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  localparam int CFG_W  = 17;
  localparam int ADDR_W = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } bfa_state_t;

endpackage

[rtl/bitmap_frame_allocator.sv]
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    in_kind, in_byte_address
// out      output     out_valid / out_stall  out_frame_address, out_ok, out_used_frames
// cfg      input      cfg_valid / cfg_ready  cfg_frame_count
//
// An in-range free or mark goes through the frame split pipeline, then a bitmap read,
// a modify-write when the bit changes and the result state before out_valid rises.
// Allocate reads and checks one bitmap word at a time on the single read port, from
// the lowest word that may hold a free frame, until a word with a free bit is found
// or the scan runs past the frame limit. Allocate on a full pool and other items go straight to the result state.
// After reset a clearing pass writes every bitmap word (WORD_COUNT, 2048 at the
// defaults) with in_stall high; configuration writes are taken throughout.
// One item at a time; the next item is accepted while a result waits under out_stall.
module bitmap_frame_allocator #(
  parameter int MAX_FRAMES = 65536,
  parameter int PAGE_SHIFT = 12,
  parameter int WORD_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_byte_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_frame_address,
  output logic        out_ok,
  output logic [16:0] out_used_frames,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_frame_count
);

  import bfa_pkg::*;

  localparam int FIDX_W     = $clog2(MAX_FRAMES);
  localparam int FB_W       = FIDX_W + 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int BI_W       = $clog2(WORD_BITS);
  localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int WC_W       = WA_W + 1;

  bfa_state_t state_r, state_nxt;

  logic [WA_W-1:0]      clr_r, clr_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [FIDX_W-1:0]    frame_r, frame_nxt;
  logic [WC_W-1:0]      word_r, word_nxt;
  logic [WC_W-1:0]      hint_r, hint_nxt;
  logic [FB_W-1:0]      base_r, base_nxt;
  logic [FB_W-1:0]      hint_base_r, hint_base_nxt;
  logic [BI_W-1:0]      bit_r, bit_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]    out_addr_r;
  logic                 out_ok_r;
  logic [CFG_W-1:0]     out_used_r;
  logic [CFG_W-1:0]     cfg_count_r;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_en;
  logic [WA_W-1:0]      rd_addr;
  logic                 wr_en;
  logic [WA_W-1:0]      wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic                 split_start;
  logic                 split_done;
  logic [WC_W-1:0]      split_word;
  logic [BI_W-1:0]      split_bit;
  logic [FB_W-1:0]      split_base;

  logic [CNT_W-1:0]     limit;
  logic                 in_accept;
  logic                 is_alloc;
  logic                 in_is_alloc;
  logic                 in_is_rmw;
  logic                 pool_full;
  logic                 in_range;
  logic                 scan_end;
  logic                 word_full;
  logic [BI_W-1:0]      zero_idx;
  logic [FB_W-1:0]      found_frame;
  logic                 found_ok;
  logic                 want;
  logic                 bit_change;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 out_load;

  function automatic logic [BI_W-1:0] low_zero(input logic [WORD_BITS-1:0] w);
    logic [BI_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) idx = BI_W'(i);
    end
    return idx;
  endfunction

  assign limit = (32'(cfg_count_r) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                      : CNT_W'(cfg_count_r);
  assign in_accept   = in_valid && !in_stall;
  assign is_alloc    = (kind_r == KIND_ALLOC);
  assign in_is_alloc = (in_kind == KIND_ALLOC);
  assign in_is_rmw   = (in_kind == KIND_FREE) || (in_kind == KIND_MARK);
  assign pool_full   = (used_r >= limit);
  assign in_range    = (33'(in_byte_address >> PAGE_SHIFT) < 33'(limit));
  assign scan_end    = (33'(base_r) >= 33'(limit));
  assign word_full   = (rd_data_r == {WORD_BITS{1'b1}});
  assign zero_idx    = low_zero(rd_data_r);
  assign found_frame = base_r + FB_W'(zero_idx);
  assign found_ok    = (33'(found_frame) < 33'(limit));
  assign want        = (kind_r == KIND_MARK);
  assign bit_change  = (rd_data_r[bit_r] != want);
  assign bit_mask    = WORD_BITS'(1) << (is_alloc ? zero_idx : bit_r);

  bfa_frame_split #(
    .MAX_FRAMES(MAX_FRAMES),
    .WORD_BITS (WORD_BITS)
  ) u_split (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (split_start),
    .frame  (frame_nxt),
    .done   (split_done),
    .word   (split_word),
    .bit_idx(split_bit),
    .base   (split_base)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == WA_W'(WORD_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_is_alloc && !pool_full) state_nxt = ST_READ;
          else if (in_is_rmw && in_range) state_nxt = ST_SPLIT;
          else state_nxt = ST_RESP;
        end
      end
      ST_SPLIT: begin
        if (split_done) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (is_alloc && scan_end) state_nxt = ST_RESP;
        else state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (is_alloc && word_full) state_nxt = ST_READ;
        else state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt       = clr_r;
    kind_nxt      = kind_r;
    frame_nxt     = frame_r;
    word_nxt      = word_r;
    hint_nxt      = hint_r;
    base_nxt      = base_r;
    hint_base_nxt = hint_base_r;
    bit_nxt       = bit_r;
    used_nxt      = used_r;
    res_addr_nxt  = res_addr_r;
    res_ok_nxt    = res_ok_r;
    in_stall      = 1'b1;
    rd_en         = 1'b0;
    rd_addr       = word_r[WA_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = word_r[WA_W-1:0];
    wr_data       = rd_data_r;
    split_start   = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + WA_W'(1);
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          kind_nxt     = in_kind;
          frame_nxt    = FIDX_W'(in_byte_address >> PAGE_SHIFT);
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b0;
          word_nxt     = hint_r;
          base_nxt     = hint_base_r;
          split_start  = in_is_rmw && in_range;
        end
      end
      ST_SPLIT: begin
        if (split_done) begin
          word_nxt = split_word;
          bit_nxt  = split_bit;
          base_nxt = split_base;
        end
      end
      ST_READ: begin
        rd_en = !(is_alloc && scan_end);
      end
      ST_CHECK: begin
        if (is_alloc) begin
          if (word_full) begin
            word_nxt      = word_r + WC_W'(1);
            base_nxt      = base_r + FB_W'(WORD_BITS);
            hint_nxt      = word_r + WC_W'(1);
            hint_base_nxt = base_r + FB_W'(WORD_BITS);
          end else begin
            hint_nxt      = word_r;
            hint_base_nxt = base_r;
            if (found_ok) begin
              wr_en        = 1'b1;
              wr_data      = rd_data_r | bit_mask;
              used_nxt     = used_r + CNT_W'(1);
              res_addr_nxt = ADDR_W'(64'(found_frame) << PAGE_SHIFT);
              res_ok_nxt   = 1'b1;
            end
          end
        end else if (bit_change) begin
          wr_en      = 1'b1;
          res_ok_nxt = 1'b1;
          if (want) begin
            wr_data  = rd_data_r | bit_mask;
            used_nxt = used_r + CNT_W'(1);
          end else begin
            wr_data  = rd_data_r & ~bit_mask;
            used_nxt = used_r - CNT_W'(1);
            if (word_r < hint_r) begin
              hint_nxt      = word_r;
              hint_base_nxt = base_r;
            end
          end
        end
      end
      ST_RESP: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      hint_r      <= '0;
      hint_base_r <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      cfg_count_r <= 17'h10000;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hint_r      <= hint_nxt;
      hint_base_r <= hint_base_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) cfg_count_r <= cfg_frame_count;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    frame_r    <= frame_nxt;
    word_r     <= word_nxt;
    base_r     <= base_nxt;
    bit_r      <= bit_nxt;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    if (out_load) begin
      out_addr_r <= res_addr_r;
      out_ok_r   <= res_ok_r;
      out_used_r <= CFG_W'(used_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_ok            = out_ok_r;
  assign out_used_frames   = out_used_r;

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |->
      (used_r == $past(used_r) + CNT_W'(1) || used_r == $past(used_r) - CNT_W'(1)))
    else $error("used count moved by more than one");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (in_stall && !out_valid_r))
    else $error("item traffic during bitmap clear");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == ST_RESP))
    else $error("result raised outside the result state");

  a_write_changes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && wr_en) |=> (used_r != $past(used_r)))
    else $error("bitmap write without count update");

endmodule

[rtl/bfa_frame_split.sv]
module bfa_frame_split #(
  parameter int MAX_FRAMES = 65536,
  parameter int WORD_BITS  = 32
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic [$clog2(MAX_FRAMES)-1:0]                frame,
  output logic                                         done,
  output logic [((((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) > 1) ?
                 $clog2((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) : 1):0] word,
  output logic [$clog2(WORD_BITS)-1:0]                 bit_idx,
  output logic [$clog2(MAX_FRAMES):0]                  base
);

  localparam int FIDX_W     = $clog2(MAX_FRAMES);
  localparam int BI_W       = $clog2(WORD_BITS);
  localparam int RB_W       = BI_W + 1;
  localparam int FB_W       = FIDX_W + 1;
  localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int WC_W       = WA_W + 1;
  localparam int S_SH       = FIDX_W + 7;
  localparam int RC_W       = S_SH - 2;
  localparam int PROD_W     = FIDX_W + RC_W;
  localparam logic [RC_W-1:0] RECIP = RC_W'((64'd1 << S_SH) / WORD_BITS);

  logic              s1_v_r;
  logic [FIDX_W-1:0] s1_frame_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic              s2_v_r;
  logic [WC_W-1:0]   s2_q_r;
  logic [FB_W-1:0]   s2_qwb_r;
  logic [RB_W-1:0]   s2_rem_r;
  logic              s3_v_r;
  logic [WC_W-1:0]   s3_word_r;
  logic [BI_W-1:0]   s3_bit_r;
  logic [FB_W-1:0]   s3_base_r;

  logic [FB_W-1:0]   q0;
  logic [FB_W-1:0]   qwb;
  logic [FB_W-1:0]   rem0;

  assign q0   = FB_W'(s1_prod_r >> S_SH);
  assign qwb  = FB_W'(q0 * FB_W'(WORD_BITS));
  assign rem0 = FB_W'(s1_frame_r) - qwb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= start;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_frame_r <= frame;
    s1_prod_r  <= PROD_W'(frame) * PROD_W'(RECIP);
    s2_q_r     <= WC_W'(q0);
    s2_qwb_r   <= qwb;
    s2_rem_r   <= RB_W'(rem0);
    if (s2_rem_r >= RB_W'(WORD_BITS)) begin
      s3_word_r <= s2_q_r + WC_W'(1);
      s3_bit_r  <= BI_W'(s2_rem_r - RB_W'(WORD_BITS));
      s3_base_r <= s2_qwb_r + FB_W'(WORD_BITS);
    end else begin
      s3_word_r <= s2_q_r;
      s3_bit_r  <= BI_W'(s2_rem_r);
      s3_base_r <= s2_qwb_r;
    end
  end

  assign done    = s3_v_r;
  assign word    = s3_word_r;
  assign bit_idx = s3_bit_r;
  assign base    = s3_base_r;

endmodule

[test/bitmap_frame_allocator_test.sv]
`timescale 1ns / 100ps

module bitmap_frame_allocator_test;
  import bfa_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int MAX_FRAMES     = 65536;
  localparam int PAGE_SHIFT     = 12;
  localparam int WORD_BITS      = 32;
  localparam int MAP_WORDS      = MAX_FRAMES / WORD_BITS;
  localparam int STALL_PCT      = 23;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_ITEM   = 300;
  localparam int QUIET_FROM     = 600;
  localparam int QUIET_TO       = 850;
  localparam int PHASE_ITEMS    = 125;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 40;

  typedef struct {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] byte_address;
  } frame_req_t;

  typedef struct {
    logic [ADDR_W-1:0] frame_address;
    logic              ok;
    logic [CFG_W-1:0]  used_frames;
  } frame_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_kind = KIND_ALLOC;
  logic [ADDR_W-1:0] in_byte_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] out_frame_address;
  logic              out_ok;
  logic [CFG_W-1:0]  out_used_frames;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_frame_count = '0;

  frame_req_t pending_reqs[$];
  frame_res_t due_results[$];
  frame_req_t next_req;
  frame_res_t predicted;
  frame_res_t oldest;

  logic [WORD_BITS-1:0] frame_map [MAP_WORDS] = '{default: '0};
  int unsigned          used_tally = 0;
  logic [CFG_W-1:0]     frame_count_reg = 17'd65536;

  int unsigned accepted_items = 0;
  int unsigned result_items = 0;
  int unsigned alloc_hits = 0;
  int unsigned alloc_misses = 0;
  int unsigned bit_changes = 0;
  int unsigned ignored_reqs = 0;
  int unsigned frame_count_writes = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;
  logic        quiet;

  assign quiet = accepted_items >= QUIET_FROM && accepted_items < QUIET_TO;

  bitmap_frame_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_byte_address   (in_byte_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_address (out_frame_address),
    .out_ok            (out_ok),
    .out_used_frames   (out_used_frames),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frame_count   (cfg_frame_count)
  );

  always #2 clk = ~clk;

  function automatic frame_res_t apply_request(frame_req_t req);
    frame_res_t  res;
    int unsigned cap;
    int unsigned frame;
    bit          want;
    bit          done;
    res.frame_address = '0;
    res.ok = 1'b0;
    cap = (frame_count_reg > MAX_FRAMES) ? MAX_FRAMES : frame_count_reg;
    frame = req.byte_address >> PAGE_SHIFT;
    if (req.kind == KIND_ALLOC) begin
      done = (used_tally >= cap);
      for (int w = 0; w < MAP_WORDS && !done; w++) begin
        if (frame_map[w] != '1) begin
          for (int b = 0; b < WORD_BITS && !done; b++) begin
            if (w * WORD_BITS + b >= cap) begin
              done = 1'b1;
            end else if (!frame_map[w][b]) begin
              frame_map[w][b] = 1'b1;
              used_tally++;
              res.frame_address = (w * WORD_BITS + b) << PAGE_SHIFT;
              res.ok = 1'b1;
              done = 1'b1;
            end
          end
        end
      end
    end else if (req.kind == KIND_FREE || req.kind == KIND_MARK) begin
      want = (req.kind == KIND_MARK);
      if (frame < cap && frame_map[frame / WORD_BITS][frame % WORD_BITS] != want) begin
        frame_map[frame / WORD_BITS][frame % WORD_BITS] = want;
        if (want) begin
          used_tally++;
        end else begin
          used_tally--;
        end
        res.ok = 1'b1;
      end
    end
    res.used_frames = used_tally[CFG_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h", $realtime, result_items,
             what, got, want);
    mismatches++;
  endtask

  function automatic void push_req(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
    pending_reqs.push_back('{kind: kind, byte_address: addr});
  endfunction

  task automatic write_frame_count(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_frame_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  // driver: hold a stalled item, otherwise load the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= STALL_PCT)) begin
        next_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_kind <= next_req.kind;
        in_byte_address <= next_req.byte_address;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_used && accepted_items == HOLD_AT_ITEM) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      out_stall <= !quiet && $urandom_range(0, 99) < STALL_PCT;
    end
  end

  // monitor: predict on accept, check results in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        frame_count_reg <= cfg_frame_count;
        frame_count_writes++;
      end
      if (in_valid && !in_stall) begin
        predicted = apply_request('{kind: in_kind, byte_address: in_byte_address});
        due_results.push_back(predicted);
        accepted_items++;
        if (in_kind == KIND_ALLOC) begin
          if (predicted.ok) alloc_hits++;
          else alloc_misses++;
        end else begin
          if (predicted.ok) bit_changes++;
          else ignored_reqs++;
        end
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected item", out_frame_address, '0);
        end else begin
          oldest = due_results.pop_front();
          if (out_frame_address !== oldest.frame_address)
            report_mismatch("frame_address", out_frame_address, oldest.frame_address);
          if (out_ok !== oldest.ok)
            report_mismatch("ok", 32'(out_ok), 32'(oldest.ok));
          if (out_used_frames !== oldest.used_frames)
            report_mismatch("used_frames", 32'(out_used_frames), 32'(oldest.used_frames));
        end
        result_items++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("[bitmap_frame_allocator] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0]  phase_caps [10] = '{17'd37, 17'd131071, 17'd1, 17'd100, 17'd0,
                                           17'd33, 17'd2000, 17'd64, 17'd5, 17'd65536};
    int unsigned       cap;
    int unsigned       pick;
    int unsigned       roll;
    int unsigned       frame;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;

    // directed: full range at the reset frame count
    push_req(KIND_ALLOC, 32'h0000_0000);
    push_req(KIND_ALLOC, 32'hFFFF_FFFF);
    push_req(KIND_MARK,  32'h0000_5ABC);
    push_req(KIND_ALLOC, 32'h0000_0000);
    push_req(KIND_FREE,  32'h0000_1000);
    push_req(KIND_FREE,  32'h0000_1FFF);
    push_req(KIND_MARK,  32'h0000_0000);
    push_req(KIND_NONE,  32'hFFFF_FFFF);
    push_req(KIND_FREE,  32'hFFFF_FFFF);
    push_req(KIND_MARK,  32'h0FFF_F000);
    push_req(KIND_MARK,  32'h1000_0000);
    push_req(KIND_ALLOC, 32'h5555_5555);
    push_req(KIND_FREE,  32'h0FFF_FFFF);
    push_req(KIND_MARK,  32'hAAAA_A000);
    push_req(KIND_FREE,  32'h5555_5555);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // empty pool, then a limit below frames already in use
    write_frame_count(17'd0);
    push_req(KIND_ALLOC, 32'h0000_0000);
    push_req(KIND_MARK,  32'h0000_3000);
    push_req(KIND_FREE,  32'h0000_0000);
    wait_drained();
    write_frame_count(17'd2);
    push_req(KIND_ALLOC, 32'h0000_0000);
    push_req(KIND_FREE,  32'h0000_1000);
    push_req(KIND_ALLOC, 32'h0000_0000);
    push_req(KIND_FREE,  32'h0000_5000);
    push_req(KIND_MARK,  32'h0000_5000);
    push_req(KIND_FREE,  32'h0000_0000);
    push_req(KIND_ALLOC, 32'h0000_0000);
    wait_drained();

    foreach (phase_caps[p]) begin
      write_frame_count(phase_caps[p]);
      cap = (phase_caps[p] > MAX_FRAMES) ? MAX_FRAMES : phase_caps[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) kind = KIND_ALLOC;
        else if (pick < 70) kind = KIND_FREE;
        else if (pick < 96) kind = KIND_MARK;
        else kind = KIND_NONE;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          addr = $urandom;
        end else begin
          if (roll < 16 && cap > 128) frame = cap + 3 - $urandom_range(0, 40);
          else frame = $urandom_range(0, (cap < 120) ? cap + 4 : 124);
          addr = (frame << PAGE_SHIFT) | ($urandom & 32'hFFF);
        end
        push_req(kind, addr);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch("results missing", '0, 32'(due_results.size()));
    $display("Covered %0d requests over %0d frame count writes: %0d allocations, %0d failed",
             accepted_items, frame_count_writes, alloc_hits, alloc_misses);
    $display("  %0d free/mark updates, %0d ignored requests, %0d mismatches",
             bit_changes, ignored_reqs, mismatches);
    if (mismatches == 0) begin
      $display("[bitmap_frame_allocator] OK");
    end else begin
      $display("[bitmap_frame_allocator] ERROR");
    end
    $finish;
  end

endmodule
